@@ hdl/lagi_pkg.sv @@
// ----------------------------------------------------------------------------
// lagi_pkg
// Shared types and constants of the Lagrange interpolator.
// ----------------------------------------------------------------------------
package lagi_pkg;

    localparam int MAX_POINTS_DEF = 8;
    localparam int XY_W           = 32;
    localparam int KIND_W         = 2;
    localparam int STAT_W         = 2;
    localparam int TERM_W         = 63;   // signed, holds +-2^61
    localparam int MAG_W          = 62;   // magnitude up to 2^61
    localparam int DIF_W          = 33;   // magnitude of a 33-bit difference
    localparam int PROD_W         = MAG_W + DIF_W;

    localparam logic [MAG_W-1:0] TERM_LIM = MAG_W'(64'd1 << 61);

    typedef enum logic [KIND_W-1:0] {
        K_CLEAR  = 2'd0,
        K_APPEND = 2'd1,
        K_EVAL   = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_INTERP = 2'd0,
        ST_EXACT  = 2'd1,
        ST_ORDER  = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // request and answer between the sequencer and the multiply-divide unit
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] a;
        logic [DIF_W-1:0] b;
        logic [DIF_W-1:0] d;
    } t_md_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] q;
    } t_md_rsp;

endpackage

@@ hdl/lagi_if.sv @@
// ----------------------------------------------------------------------------
// lagi_in_if / lagi_out_if
// Valid/ready channels of the Lagrange interpolator.
// ----------------------------------------------------------------------------
interface lagi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    modport source (output valid, kind, x_value, y_value, input ready);
    modport sink   (input valid, kind, x_value, y_value, output ready);
endinterface

interface lagi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

@@ hdl/lagi_muldiv.sv @@
// ----------------------------------------------------------------------------
// lagi_muldiv
// round(a * b / d) on magnitudes, halves up, saturated to 2^61.
// Multiply by shift-add one bit per cycle, then restoring division one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module lagi_muldiv
    import lagi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;

    localparam int CNT_W = $clog2(PROD_W + 1);

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_quo;
    logic [DIF_W:0]      r_rem;
    logic [MAG_W-1:0]    r_a;
    logic [DIF_W-1:0]    r_b;
    logic [DIF_W-1:0]    r_d;
    logic                r_done;
    logic [MAG_W-1:0]    r_q;

    logic [DIF_W:0]      n_rem_sh;
    logic [DIF_W:0]      n_rem_sub;
    logic                n_ge;
    logic [DIF_W:0]      n_half;
    logic [PROD_W:0]     n_rnd;

    // shift in one dividend bit and try the subtract
    always_comb begin
        n_rem_sh  = {r_rem[DIF_W-1:0], r_prod[PROD_W-1]};
        n_ge      = n_rem_sh >= {1'b0, r_d};
        n_rem_sub = n_ge ? n_rem_sh - {1'b0, r_d} : n_rem_sh;
        n_half    = {1'b0, r_d} - r_rem;
        n_rnd     = {1'b0, r_quo} + ((r_rem >= n_half) ? (PROD_W+1)'(1) : '0);
    end

    // sequence multiply, divide, round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_a    <= i_req.a;
                        r_b    <= i_req.b;
                        r_d    <= i_req.d;
                        r_prod <= '0;
                        r_cnt  <= CNT_W'(DIF_W);
                        if (i_req.d == '0) begin
                            r_q     <= TERM_LIM;
                            r_done  <= 1'b1;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= (r_prod << 1)
                        + (r_b[DIF_W-1] ? PROD_W'(r_a) : '0);
                    r_b    <= r_b << 1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DIV;
                        r_cnt   <= CNT_W'(PROD_W);
                        r_rem   <= '0;
                        r_quo   <= '0;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem_sub;
                    r_quo  <= {r_quo[PROD_W-2:0], n_ge};
                    r_prod <= r_prod << 1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (r_quo >= PROD_W'(TERM_LIM) || n_rnd > (PROD_W+1)'(TERM_LIM)) begin
                        r_q <= TERM_LIM;
                    end else begin
                        r_q <= n_rnd[MAG_W-1:0];
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

@@ hdl/lagrange_interpolator.sv @@
// ----------------------------------------------------------------------------
// lagrange_interpolator
// Stores up to MAX_POINTS (x, y) points in Q16.16 and evaluates the
// Lagrange polynomial through them at a query x.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries kind, x_value, y_value. kind clear and append
//   produce no result; evaluate produces one result (result_value, status).
//   Points live in two synchronous memories (x and y), one read per cycle.
//   Evaluation walks the points for the exact-hit and order checks, then
//   forms n*(n-1) multiply-divide steps in one shared unit, each step
//   including its operand read. One item is worked on at a time; the
//   result moves to an output register, and the next item is taken while
//   it waits there. A further result is held in the sequencer until the
//   output register is free, and the input stays stalled meanwhile.
//   Reset empties the point set; memory contents need no clearing.
//   A stalled receiver holds the result stable until transferred.
// ----------------------------------------------------------------------------
module lagrange_interpolator
    import lagi_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lagi_in_if.sink    i_in,
    lagi_out_if.source o_out
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK_RD, S_CHK, S_J_RD, S_J, S_K_RD, S_K, S_MD_WAIT,
        S_ACC, S_DONE
    } t_state;

    // point memories
    logic [XY_W-1:0] r_mem_x [MAX_POINTS];
    logic [XY_W-1:0] r_mem_y [MAX_POINTS];
    logic [XY_W-1:0] r_rd_x;
    logic [XY_W-1:0] r_rd_y;
    logic [IDX_W-1:0] n_raddr;
    logic             n_we;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_j;
    logic [CNT_W-1:0]     r_k;
    logic signed [XY_W-1:0] r_qx;
    logic signed [XY_W-1:0] r_prev_x;
    logic signed [XY_W-1:0] r_xj;
    logic signed [TERM_W-1:0] r_term;
    logic signed [TERM_W-1:0] r_acc;
    logic                 r_neg;
    logic                 r_md_start;
    logic [MAG_W-1:0]     r_md_a;
    logic [DIF_W-1:0]     r_md_b;
    logic [DIF_W-1:0]     r_md_d;
    logic                 r_ovalid;
    logic signed [XY_W-1:0] r_ores;
    logic [STAT_W-1:0]    r_ostat;
    logic signed [XY_W-1:0] r_out_res;
    logic [STAT_W-1:0]    r_out_stat;

    t_md_req md_req;
    t_md_rsp md_rsp;

    logic signed [DIF_W-1:0] n_num;
    logic signed [DIF_W-1:0] n_den;
    logic signed [TERM_W:0]  n_sum;
    logic                    n_in_ok;

    assign n_in_ok = (r_state == S_IDLE);
    assign i_in.ready = n_in_ok;

    // write port: append while not full
    assign n_we = i_in.valid && n_in_ok && (t_kind'(i_in.kind) == K_APPEND)
                  && (r_count < CNT_W'(MAX_POINTS));

    // read address follows the sequencer
    always_comb begin
        case (r_state)
            S_CHK_RD: n_raddr = r_j[IDX_W-1:0];
            S_J_RD:   n_raddr = r_j[IDX_W-1:0];
            S_K_RD:   n_raddr = r_k[IDX_W-1:0];
            default:  n_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem_x[r_count[IDX_W-1:0]] <= i_in.x_value;
            r_mem_y[r_count[IDX_W-1:0]] <= i_in.y_value;
        end
        r_rd_x <= r_mem_x[n_raddr];
        r_rd_y <= r_mem_y[n_raddr];
    end

    // differences for the current factor
    assign n_num = DIF_W'(r_qx) - DIF_W'($signed(r_rd_x));
    assign n_den = DIF_W'(r_xj) - DIF_W'($signed(r_rd_x));
    assign n_sum = (TERM_W+1)'(r_acc) + (TERM_W+1)'(r_term);

    assign md_req.start = r_md_start;
    assign md_req.a     = r_md_a;
    assign md_req.b     = r_md_b;
    assign md_req.d     = r_md_d;

    lagi_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_md_start <= 1'b0;
        end else begin
            r_md_start <= 1'b0;
            // output register: load a finished result, drop it once transferred
            if (r_state == S_DONE && (!r_ovalid || o_out.ready)) begin
                r_ovalid   <= 1'b1;
                r_out_res  <= r_ores;
                r_out_stat <= r_ostat;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && n_in_ok) begin
                        case (t_kind'(i_in.kind))
                            K_CLEAR:  r_count <= '0;
                            K_APPEND: if (n_we) r_count <= r_count + 1'b1;
                            K_EVAL: begin
                                r_qx <= i_in.x_value;
                                r_j  <= '0;
                                if (r_count == '0) begin
                                    r_ores  <= '0;
                                    r_ostat <= ST_EMPTY;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_CHK_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHK_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_j != '0 && $signed(r_rd_x) <= r_prev_x) begin
                        r_ores  <= '0;
                        r_ostat <= ST_ORDER;
                        r_state <= S_DONE;
                    end else if ($signed(r_rd_x) == r_qx) begin
                        r_ores  <= r_rd_y;
                        r_ostat <= ST_EXACT;
                        r_state <= S_DONE;
                    end else if (r_j + 1'b1 == r_count) begin
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= S_J_RD;
                    end else begin
                        r_prev_x <= r_rd_x;
                        r_j      <= r_j + 1'b1;
                        r_state  <= S_CHK_RD;
                    end
                end
                S_J_RD: r_state <= S_J;
                S_J: begin
                    r_xj    <= r_rd_x;
                    r_term  <= TERM_W'($signed(r_rd_y));
                    r_k     <= (r_j == '0) ? CNT_W'(1) : '0;
                    r_state <= (r_count == CNT_W'(1)) ? S_ACC : S_K_RD;
                end
                S_K_RD: r_state <= S_K;
                S_K: begin
                    r_neg      <= r_term[TERM_W-1] ^ (n_num[DIF_W-1] ^ n_den[DIF_W-1]);
                    r_md_a     <= r_term[TERM_W-1] ? MAG_W'(-r_term) : MAG_W'(r_term);
                    r_md_b     <= n_num[DIF_W-1] ? DIF_W'(-n_num) : DIF_W'(n_num);
                    r_md_d     <= n_den[DIF_W-1] ? DIF_W'(-n_den) : DIF_W'(n_den);
                    r_md_start <= 1'b1;
                    r_state    <= S_MD_WAIT;
                end
                S_MD_WAIT: begin
                    if (md_rsp.done) begin
                        r_term <= r_neg ? -TERM_W'(md_rsp.q) : TERM_W'(md_rsp.q);
                        // next k, skipping j
                        if (r_k + 1'b1 == r_j) begin
                            r_k <= r_k + CNT_W'(2);
                            r_state <= (r_k + CNT_W'(2) >= r_count) ? S_ACC : S_K_RD;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_state <= (r_k + 1'b1 >= r_count) ? S_ACC : S_K_RD;
                        end
                    end
                end
                S_ACC: begin
                    if (n_sum > (TERM_W+1)'($signed({1'b0, TERM_LIM}))) begin
                        r_acc <= TERM_W'($signed({1'b0, TERM_LIM}));
                    end else if (n_sum < -(TERM_W+1)'($signed({1'b0, TERM_LIM}))) begin
                        r_acc <= -TERM_W'($signed({1'b0, TERM_LIM}));
                    end else begin
                        r_acc <= n_sum[TERM_W-1:0];
                    end
                    if (r_j + 1'b1 == r_count) begin
                        r_state <= S_DONE;
                        r_ostat <= ST_INTERP;
                        if (n_sum > (TERM_W+1)'(32'sh7fffffff)) begin
                            r_ores <= 32'sh7fffffff;
                        end else if (n_sum < -(TERM_W+1)'(64'sh80000000)) begin
                            r_ores <= 32'sh80000000;
                        end else begin
                            r_ores <= n_sum[XY_W-1:0];
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_J_RD;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || o_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.result_value = r_out_res;
    assign o_out.status       = r_out_stat;

endmodule

@@ test/lagrange_interpolator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagrange_interpolator_tb
// Drives clear, append and evaluate transfers into the interpolator, predicts
// each evaluation result in fixed point and compares value and status.
// ----------------------------------------------------------------------------
module lagrange_interpolator_tb
    import lagi_pkg::*;
;

    localparam int NPTS      = MAX_POINTS_DEF;
    localparam int CYC_LIMIT = 40000000;
    localparam longint SUM_LIM = longint'(1) << 61;

    // ------------------------------------------------------------------------
    // Scoreboard: point set shadow, expected evaluation answers
    // ------------------------------------------------------------------------
    class interp_scoreboard;
        logic signed [31:0] pt_x [NPTS];
        logic signed [31:0] pt_y [NPTS];
        int                 n_pts;
        logic signed [31:0] want_val [$];
        t_status            want_st  [$];
        int                 n_err;
        int                 n_chk;
        int                 st_seen [4];

        function new();
            n_pts = 0;
            n_err = 0;
            n_chk = 0;
            foreach (st_seen[i]) st_seen[i] = 0;
        endfunction

        // round(a * b / d), halves away from zero, clamped to 2^61
        function longint scaled_mag(longint a, longint b, longint d);
            logic [127:0] prod, quo, rem;
            longint       val;
            if (d == 0) return SUM_LIM;
            prod = 128'(a) * 128'(b);
            quo  = prod / 128'(d);
            rem  = prod % 128'(d);
            if (quo >= 128'(SUM_LIM)) return SUM_LIM;
            val = longint'(quo);
            if (rem >= 128'(d) - rem) val += 1;
            return (val > SUM_LIM) ? SUM_LIM : val;
        endfunction

        // evaluate the polynomial through the stored points at q
        function void eval_at(logic signed [31:0] q, output logic signed [31:0] res,
                              output t_status st);
            longint acc, term, num, den, m;
            bit     neg;
            res = '0;
            if (n_pts == 0) begin
                st = ST_EMPTY;
                return;
            end
            if (q == pt_x[0]) begin
                res = pt_y[0];
                st  = ST_EXACT;
                return;
            end
            for (int j = 1; j < n_pts; j++) begin
                if (pt_x[j] <= pt_x[j-1]) begin
                    st = ST_ORDER;
                    return;
                end
                if (q == pt_x[j]) begin
                    res = pt_y[j];
                    st  = ST_EXACT;
                    return;
                end
            end
            acc = 0;
            for (int j = 0; j < n_pts; j++) begin
                term = longint'(pt_y[j]);
                for (int k = 0; k < n_pts; k++) begin
                    if (k == j) continue;
                    num  = longint'(q) - longint'(pt_x[k]);
                    den  = longint'(pt_x[j]) - longint'(pt_x[k]);
                    neg  = (term < 0) != ((num < 0) != (den < 0));
                    m    = scaled_mag(term < 0 ? -term : term, num < 0 ? -num : num,
                                      den < 0 ? -den : den);
                    term = neg ? -m : m;
                end
                acc = acc + term;
                if (acc > SUM_LIM) acc = SUM_LIM;
                if (acc < -SUM_LIM) acc = -SUM_LIM;
            end
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            res = acc[31:0];
            st  = ST_INTERP;
        endfunction

        // note an accepted input transfer
        function void note_input(t_kind kd, logic signed [31:0] xv, logic signed [31:0] yv);
            logic signed [31:0] r;
            t_status            s;
            case (kd)
                K_CLEAR: n_pts = 0;
                K_APPEND: begin
                    if (n_pts < NPTS) begin
                        pt_x[n_pts] = xv;
                        pt_y[n_pts] = yv;
                        n_pts++;
                    end
                end
                K_EVAL: begin
                    eval_at(xv, r, s);
                    want_val.push_back(r);
                    want_st.push_back(s);
                end
                default: ;
            endcase
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(logic signed [31:0] val, logic [1:0] st);
            logic signed [31:0] ev;
            t_status            es;
            if (want_val.size() == 0) begin
                $display("%0t: unexpected result value=%h status=%0d", $time, val, st);
                n_err++;
                return;
            end
            ev = want_val.pop_front();
            es = want_st.pop_front();
            n_chk++;
            st_seen[es]++;
            if (val !== ev) begin
                $display("%0t: result_value expected %h actual %h", $time, ev, val);
                n_err++;
            end
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                n_err++;
            end
        endfunction

        function int pending();
            return want_val.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle;
    int   n_sent;
    bit   sender_calm;

    lagi_in_if  in_ch();
    lagi_out_if out_ch();

    interp_scoreboard sb;

    lagrange_interpolator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // count cycles, stop on a hung run
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYC_LIMIT) begin
            $display("Timeout at cycle %0d", cycle);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, a stretch with no stalls
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.result_value, out_ch.status);
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else if (cycle >= 6000 && cycle < 10000)
            out_ch.ready <= 1'b0;
        else if (cycle >= 30000 && cycle < 60000)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= 29);
    end

    // offer one item and hold it until transferred
    task automatic send(t_kind kd, logic signed [31:0] xv, logic signed [31:0] yv);
        if (!sender_calm && $urandom_range(0, 99) < 29) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kd;
        in_ch.x_value <= xv;
        in_ch.y_value <= yv;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(kd, xv, yv);
        n_sent++;
    endtask

    // random point set, then several queries against it
    task automatic run_set();
        int                 n, mode, steps;
        logic signed [31:0] xs [$];
        logic signed [31:0] q;
        n    = ($urandom_range(0, 99) < 5) ? $urandom_range(8, 10) : $urandom_range(1, 4);
        mode = $urandom_range(0, 9);
        send(K_CLEAR, $urandom, $urandom);
        if (mode == 0) begin
            // noise: unordered full-range abscissas
            repeat (n) xs.push_back($urandom);
        end else begin
            xs.push_back(mode == 1 ? $urandom : $signed($urandom_range(0, 32'h000a_0000))
                         - 32'sh0005_0000);
            for (int i = 1; i < n; i++)
                xs.push_back(xs[i-1] + ((mode == 1) ? $urandom_range(1, 32'h0fff_ffff)
                                                    : $urandom_range(1, 32'h0002_0000)));
        end
        foreach (xs[i])
            send(K_APPEND, xs[i],
                 (mode <= 2) ? $urandom : $signed($urandom_range(0, 32'h0020_0000))
                 - 32'sh0010_0000);
        steps = $urandom_range(1, 4);
        repeat (steps) begin
            case ($urandom_range(0, 5))
                0: q = xs[$urandom_range(0, xs.size() - 1)];
                1: q = $urandom;
                default: q = xs[0] + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0001_0000;
            endcase
            send(K_EVAL, q, $urandom);
            if ($urandom_range(0, 19) == 0) send(K_NONE, $urandom, $urandom);
        end
    endtask

    initial begin
        sb            = new();
        cycle         = 0;
        n_sent        = 0;
        sender_calm   = 1'b0;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = K_CLEAR;
        in_ch.x_value = '0;
        in_ch.y_value = '0;
        out_ch.ready  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set, ignored kind, single point
        send(K_EVAL, 32'sh0001_0000, '0);
        send(K_NONE, 32'sh0001_0000, 32'sh0001_0000);
        send(K_EVAL, '0, '0);
        send(K_APPEND, 32'sh0002_0000, 32'sh0003_0000);
        send(K_EVAL, 32'sh0002_0000, '0);
        send(K_EVAL, 32'sh0005_0000, '0);
        // two points: interpolation and a hit on the second
        send(K_APPEND, 32'sh0004_0000, -32'sh0001_8000);
        send(K_EVAL, 32'sh0003_0000, '0);
        send(K_EVAL, 32'sh0004_0000, '0);
        // equal abscissa: order error
        send(K_APPEND, 32'sh0004_0000, 32'sh0001_0000);
        send(K_EVAL, 32'sh0003_0000, '0);
        // extremes: saturation of the sum, and an exact hit on the first point
        send(K_CLEAR, '0, '0);
        send(K_APPEND, 32'sh8000_0000, 32'sh7fff_ffff);
        send(K_APPEND, 32'sh8000_0001, 32'sh8000_0000);
        send(K_EVAL, 32'sh7fff_ffff, '0);
        send(K_EVAL, 32'sh8000_0000, '0);
        // fill past capacity, the extra point is dropped
        send(K_CLEAR, '0, '0);
        for (int i = 0; i < NPTS + 1; i++)
            send(K_APPEND, i * 32'sh0001_0000, (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000);
        send(K_EVAL, 32'sh0000_8000, '0);
        send(K_EVAL, (NPTS) * 32'sh0001_0000, '0);

        // random point sets, one calm stretch without sender gaps
        while (n_sent < 1000) begin
            sender_calm = (n_sent >= 400 && n_sent < 550);
            run_set();
        end
        @(posedge i_clk);
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d items, checked %0d evaluations", n_sent, sb.n_chk);
        $display("Status counts: interp %0d exact %0d order %0d empty %0d",
                 sb.st_seen[0], sb.st_seen[1], sb.st_seen[2], sb.st_seen[3]);
        if (sb.n_err == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
hdl/lagi_pkg.sv
hdl/lagi_if.sv
hdl/lagi_muldiv.sv
hdl/lagrange_interpolator.sv
test/lagrange_interpolator_tb.sv
